FILE: rtl/core/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define GBPI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gbpi assertion failed");

// next-cycle implication, disabled during reset
`define GBPI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gbpi assertion failed");

`endif

FILE: rtl/core/gbpi_pkg.sv
`timescale 1ns / 1ps
package gbpi_pkg;

  // default sizes
  localparam int MAX_BINS_DEF = 64;
  localparam int EXP_DEPTH_DEF = 1024;
  localparam int QUEUE_DEPTH = 2;

  // fixed-point constants
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] LN2_Q32 = 64'd2977044472;
  localparam logic [16:0] PROB_ONE = 17'd65536;

  // register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 1'b1;

  typedef struct packed {
    logic [31:0] pair_distance;
    logic [31:0] bin_center;
    logic [16:0] bin_probability;
    logic        last_bin;
    logic        last_pair;
  } in_item_t;

  typedef struct packed {
    logic [16:0]        pair_value;
    logic signed [47:0] pair_gradient;
    logic [31:0]        total_value;
    logic               total_final;
  } out_item_t;

  // classified bin as it sits in the queue
  typedef struct packed {
    logic [31:0] mag;
    logic        neg;
    logic [16:0] prob;
    logic        last_bin;
    logic        last_pair;
  } bin_entry_t;

endpackage

FILE: rtl/core/gaussian_bin_probability_interpolate_core.sv
`timescale 1ns / 1ps
// Gaussian bin interpolation: items are distance bins of one atom pair; each
// bin up to MAX_BINS passes through the back sequencer (square, scale, table
// exponential, three products, accumulate), and the last bin of a pair adds
// three bit-serial 33-step divisions, skipped for a zero denominator, that
// form the smoothed probability and the two offset quotients. A two-entry
// queue keeps the input side taking bins while the back works, and an output
// register holds the finished pair result while later bins are being taken.
module gaussian_bin_probability_interpolate_core #(
  parameter int MAX_BINS = gbpi_pkg::MAX_BINS_DEF,
  parameter int EXP_TABLE_DEPTH = gbpi_pkg::EXP_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  gbpi_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output gbpi_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [gbpi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);

  import gbpi_pkg::*;

  logic [23:0] lambda;
  logic [31:0] epsilon;
  logic        q_full;
  logic        q_push;
  bin_entry_t  q_wdata;
  logic        q_pop;
  bin_entry_t  q_rdata;
  logic        q_valid;
  logic        res_valid;
  out_item_t   res_data;
  logic        res_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lambda  <= 24'd256;
      epsilon <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LAMBDA:  lambda  <= cfg_data[23:0];
        CFG_EPSILON: epsilon <= cfg_data;
        default: ;
      endcase
    end
  end

  gbpi_front u_front (
    .in_valid(in_valid),
    .in_data (in_data),
    .in_stall(in_stall),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  gbpi_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .valid(q_valid)
  );

  gbpi_back #(
    .MAX_BINS       (MAX_BINS),
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .lambda   (lambda),
    .epsilon  (epsilon),
    .q_valid  (q_valid),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .res_valid(res_valid),
    .res_data (res_data),
    .res_ready(res_ready)
  );

  // output register
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res_data;
    end
  end

endmodule

FILE: rtl/core/gbpi_div.sv
`timescale 1ns / 1ps
module gbpi_div #(
  parameter int NUM_W = 88,
  parameter int QUO_W = 33,
  parameter int DEN_W = 41
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] low;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // one restoring step per cycle; the upper numerator part is below den
  assign trial = {rem, low[QUO_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        rem    <= DEN_W'(num[NUM_W-1:QUO_W]);
        low    <= num[QUO_W-1:0];
      end else if (active) begin
        rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo <= {quo[QUO_W-2:0], ge};
        low <= {low[QUO_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QUO_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/gbpi_front.sv
`timescale 1ns / 1ps
module gbpi_front (
  input  logic                  in_valid,
  input  gbpi_pkg::in_item_t    in_data,
  output logic                  in_stall,
  input  logic                  q_full,
  output logic                  q_push,
  output gbpi_pkg::bin_entry_t  q_wdata
);

  import gbpi_pkg::*;

  logic neg;

  // accept whenever the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // offset sign and magnitude, probability clamped to one
  assign neg               = in_data.bin_center < in_data.pair_distance;
  assign q_wdata.mag       = neg ? in_data.pair_distance - in_data.bin_center
                                 : in_data.bin_center - in_data.pair_distance;
  assign q_wdata.neg       = neg;
  assign q_wdata.prob      = (in_data.bin_probability > PROB_ONE) ? PROB_ONE
                                                                  : in_data.bin_probability;
  assign q_wdata.last_bin  = in_data.last_bin;
  assign q_wdata.last_pair = in_data.last_pair;

endmodule

FILE: rtl/core/gbpi_queue.sv
`timescale 1ns / 1ps
module gbpi_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  gbpi_pkg::bin_entry_t wdata,
  output logic                 full,
  input  logic                 pop,
  output gbpi_pkg::bin_entry_t rdata,
  output logic                 valid
);

  import gbpi_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bin_entry_t       entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign rdata = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: rtl/core/gbpi_back.sv
`timescale 1ns / 1ps
module gbpi_back #(
  parameter int MAX_BINS = gbpi_pkg::MAX_BINS_DEF,
  parameter int EXP_TABLE_DEPTH = gbpi_pkg::EXP_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [23:0]          lambda,
  input  logic [31:0]          epsilon,
  input  logic                 q_valid,
  input  gbpi_pkg::bin_entry_t q_data,
  output logic                 q_pop,
  output logic                 res_valid,
  output gbpi_pkg::out_item_t  res_data,
  input  logic                 res_ready
);

  import gbpi_pkg::*;

  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int CNT_W = $clog2(MAX_BINS + 1);

  // exponential table: 2^(-k/depth) in Q0.32 from a truncated series
  typedef logic [31:0] rom_array_t [EXP_TABLE_DEPTH];

  function automatic rom_array_t build_rom();
    rom_array_t  rom;
    logic [63:0] a;
    logic [63:0] term;
    logic [63:0] even;
    logic [63:0] odd;
    logic [63:0] e;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      a    = (64'(k) * LN2_Q32) / EXP_TABLE_DEPTH;
      term = 64'h1_0000_0000;
      even = term;
      odd  = '0;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * a) >> 32) / 64'(n);
        if ((n % 2) == 1) odd = odd + term;
        else even = even + term;
      end
      e = (odd > even) ? 64'd0 : even - odd;
      rom[k] = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
    end
    return rom;
  endfunction

  localparam rom_array_t EXP_ROM = build_rom();

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_SQ    = 17'h00002,
    S_XH    = 17'h00004,
    S_XL    = 17'h00008,
    S_EXPY  = 17'h00010,
    S_ROM   = 17'h00020,
    S_WP    = 17'h00040,
    S_WD    = 17'h00080,
    S_WPD   = 17'h00100,
    S_ACC   = 17'h00200,
    S_FIN   = 17'h00400,
    S_DGO   = 17'h00800,
    S_DWAIT = 17'h01000,
    S_T     = 17'h02000,
    S_D     = 17'h04000,
    S_G     = 17'h08000,
    S_OUT   = 17'h10000
  } state_t;

  localparam logic [1:0] DIV_VALUE = 2'd0;
  localparam logic [1:0] DIV_Q1    = 2'd1;
  localparam logic [1:0] DIV_Q2    = 2'd2;

  state_t state;
  state_t state_next;

  bin_entry_t         ent;
  logic [CNT_W-1:0]   bin_count;
  logic [63:0]        sq;
  logic [55:0]        xh;
  logic [56:0]        x;
  logic [4:0]         n_sh;
  logic               zero_w;
  logic [IDX_W-1:0]   idx;
  logic [31:0]        w;
  logic [31:0]        wp;
  logic [39:0]        wd;
  logic [39:0]        wpd;
  logic [39:0]        weight_sum;
  logic [39:0]        weighted_prob_sum;
  logic signed [63:0] weight_offset_sum;
  logic signed [63:0] weighted_offset_prob_sum;
  logic [31:0]        pair_total;
  logic [40:0]        s_den;
  logic [1:0]         div_sel;
  logic [16:0]        value;
  logic [32:0]        q1m;
  logic [32:0]        q2m;
  logic [33:0]        tm;
  logic signed [34:0] d;
  logic signed [47:0] grad;

  // datapath intermediates
  logic [55:0] xl_prod;
  logic [59:0] y_prod;
  logic [29:0] y;
  logic [39:0] idx_full;
  logic [48:0] wp_prod;
  logic [63:0] wd_prod;
  logic [63:0] wpd_prod;
  logic [63:0] wos_mag;
  logic [63:0] wops_mag;
  logic [87:0] div_num;
  logic        div_start;
  logic        div_done;
  logic [32:0] div_quo;
  logic [49:0] tm_prod;
  logic signed [34:0] q1s;
  logic signed [34:0] ts;
  logic [34:0] dm;
  logic [58:0] gm_prod;
  logic [43:0] gm;
  logic [32:0] tot_sum;
  logic [31:0] tot;

  assign xl_prod  = 56'(lambda) * 56'(sq[31:0]);
  assign y_prod   = 60'(x[28:0]) * 60'(LOG2E_Q30);
  assign y        = y_prod[59:30];
  assign idx_full = 40'(y[23:0]) * 40'(EXP_TABLE_DEPTH);
  assign wp_prod  = 49'(w) * 49'(ent.prob);
  assign wd_prod  = 64'(w) * 64'(ent.mag);
  assign wpd_prod = 64'(wp) * 64'(ent.mag);
  assign wos_mag  = weight_offset_sum[63] ? 64'(-weight_offset_sum) : 64'(weight_offset_sum);
  assign wops_mag = weighted_offset_prob_sum[63] ? 64'(-weighted_offset_prob_sum)
                                                 : 64'(weighted_offset_prob_sum);
  assign tm_prod  = 50'(value) * 50'(q2m);
  assign q1s      = weighted_offset_prob_sum[63] ? -$signed(35'(q1m)) : $signed(35'(q1m));
  assign ts       = weight_offset_sum[63] ? -$signed(35'(tm)) : $signed(35'(tm));
  assign dm       = d[34] ? 35'(-d) : 35'(d);
  assign gm_prod  = 59'(lambda) * 59'(dm);
  assign gm       = gm_prod[58:15];
  assign tot_sum  = 33'(pair_total) + 33'(value);
  assign tot      = tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];

  // divider operand select
  always_comb begin
    case (div_sel)
      DIV_VALUE: div_num = 88'({weighted_prob_sum, 16'd0});
      DIV_Q1:    div_num = {wops_mag, 24'd0};
      DIV_Q2:    div_num = {wos_mag, 24'd0};
      default:   div_num = '0;
    endcase
  end

  gbpi_div #(
    .NUM_W(88),
    .QUO_W(33),
    .DEN_W(41)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (s_den),
    .done (div_done),
    .quo  (div_quo)
  );

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign div_start = (state == S_DGO) && (s_den != '0);
  assign res_valid = state == S_OUT;

  assign res_data.pair_value    = value;
  assign res_data.pair_gradient = grad;
  assign res_data.total_value   = tot;
  assign res_data.total_final   = ent.last_pair;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (bin_count < CNT_W'(MAX_BINS)) state_next = S_SQ;
          else if (q_data.last_bin) state_next = S_FIN;
          else state_next = S_IDLE;
        end
      end
      S_SQ:   state_next = S_XH;
      S_XH:   state_next = S_XL;
      S_XL:   state_next = S_EXPY;
      S_EXPY: state_next = S_ROM;
      S_ROM:  state_next = S_WP;
      S_WP:   state_next = S_WD;
      S_WD:   state_next = S_WPD;
      S_WPD:  state_next = S_ACC;
      S_ACC:  state_next = ent.last_bin ? S_FIN : S_IDLE;
      S_FIN:  state_next = S_DGO;
      S_DGO:  state_next = (s_den == '0) ? S_OUT : S_DWAIT;
      S_DWAIT: begin
        if (div_done) state_next = (div_sel == DIV_Q2) ? S_T : S_DGO;
      end
      S_T:    state_next = S_D;
      S_D:    state_next = S_G;
      S_G:    state_next = S_OUT;
      S_OUT: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // accumulators and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state                    <= S_IDLE;
      bin_count                <= '0;
      weight_sum               <= '0;
      weighted_prob_sum        <= '0;
      weight_offset_sum        <= '0;
      weighted_offset_prob_sum <= '0;
      pair_total               <= '0;
    end else begin
      state <= state_next;
      if (state == S_ACC) begin
        bin_count         <= bin_count + 1'b1;
        weight_sum        <= weight_sum + 40'(w);
        weighted_prob_sum <= weighted_prob_sum + 40'(wp);
        weight_offset_sum <= ent.neg ? weight_offset_sum - $signed(64'(wd))
                                     : weight_offset_sum + $signed(64'(wd));
        weighted_offset_prob_sum <= ent.neg
            ? weighted_offset_prob_sum - $signed(64'(wpd))
            : weighted_offset_prob_sum + $signed(64'(wpd));
      end
      // pair ends: fold into total, or clear it after the last pair, and start over
      if ((state == S_OUT) && res_ready) begin
        bin_count                <= '0;
        weight_sum               <= '0;
        weighted_prob_sum        <= '0;
        weight_offset_sum        <= '0;
        weighted_offset_prob_sum <= '0;
        pair_total               <= ent.last_pair ? 32'd0 : tot;
      end
    end
  end

  // per-item datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_valid) ent <= q_data;
      end
      S_SQ:  sq <= 64'(ent.mag) * 64'(ent.mag);
      S_XH:  xh <= 56'(lambda) * 56'(sq[63:32]);
      S_XL:  x  <= 57'(xh) + 57'(xl_prod[55:32]);
      S_EXPY: begin
        zero_w <= (|x[56:29]) | y[29];
        n_sh   <= y[28:24];
        idx    <= idx_full[24 +: IDX_W];
      end
      S_ROM:  w   <= zero_w ? 32'd0 : (EXP_ROM[idx] >> n_sh);
      S_WP:   wp  <= wp_prod[47:16];
      S_WD:   wd  <= wd_prod[63:24];
      S_WPD:  wpd <= wpd_prod[63:24];
      S_FIN: begin
        s_den   <= 41'(epsilon) + 41'(weight_sum);
        div_sel <= DIV_VALUE;
      end
      S_DGO: begin
        if (s_den == '0) begin
          value <= '0;
          grad  <= '0;
        end
      end
      S_DWAIT: begin
        if (div_done) begin
          case (div_sel)
            DIV_VALUE: begin
              value   <= (div_quo > 33'(PROB_ONE)) ? PROB_ONE : div_quo[16:0];
              div_sel <= DIV_Q1;
            end
            DIV_Q1: begin
              q1m     <= div_quo;
              div_sel <= DIV_Q2;
            end
            default: q2m <= div_quo;
          endcase
        end
      end
      S_T:    tm <= tm_prod[49:16];
      S_D:    d  <= q1s - ts;
      // gradient: lambda times the difference, scaled by two
      S_G:    grad <= d[34] ? -$signed(48'(gm)) : $signed(48'(gm));
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/gbpi_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gbpi_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input gbpi_pkg::out_item_t out_data
);

  import gbpi_pkg::*;

  // a stalled result holds
  `GBPI_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))

  // smoothed probability never exceeds one
  `GBPI_ASSERT_IMP(a_value_max, clk, rst, out_valid, out_data.pair_value <= PROB_ONE)

  // running total includes this pair
  `GBPI_ASSERT_IMP(a_total_ge, clk, rst, out_valid, out_data.total_value >= 32'(out_data.pair_value))

  // nothing is shown right after reset
  `GBPI_ASSERT_IMP(a_reset_quiet, clk, rst, $past(rst), !out_valid)

endmodule

bind gaussian_bin_probability_interpolate_core gbpi_checker u_gbpi_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

FILE: bench/gaussian_bin_probability_interpolate_core_tb.sv
`timescale 1ns / 1ps
module gaussian_bin_probability_interpolate_core_tb;
  import gbpi_pkg::*;

  localparam int NUM_BINS_MAX = 64;
  localparam int EXP_DEPTH = 1024;
  localparam int RANDOM_ITEMS = 800;
  localparam int DRAIN_CYCLES = 400;

  // idling phases
  typedef enum int {PH_NONE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} idle_phase_e;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  gaussian_bin_probability_interpolate_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // predictor state
  logic [31:0] exp_rom [EXP_DEPTH];
  logic [23:0] lambda_q;
  logic [31:0] epsilon_q;
  logic [63:0] acc_w;
  logic [63:0] acc_wp;
  logic signed [63:0] acc_wd;
  logic signed [63:0] acc_wpd;
  logic [31:0] running_total;
  int bins_in_pair;

  out_item_t pair_results_q[$];
  int mismatches;
  int results_seen;
  int items_sent;
  int finals_seen;
  idle_phase_e phase;

  function automatic void build_exp_rom();
    logic [63:0] a, term, even, odd, e;
    for (int k = 0; k < EXP_DEPTH; k++) begin
      a = (64'(k) * LN2_Q32) / EXP_DEPTH;
      term = 64'd1 << 32;
      even = term;
      odd = 0;
      for (int n = 1; n <= 24; n++) begin
        term = 64'((128'(term) * a) >> 32) / n;
        if (n % 2 == 1) odd += term;
        else even += term;
      end
      e = (odd > even) ? 64'd0 : even - odd;
      exp_rom[k] = (e > 64'hFFFFFFFF) ? 32'hFFFFFFFF : e[31:0];
    end
  endfunction

  function automatic logic [63:0] gauss_weight(logic [63:0] mag);
    logic [63:0] sq, lam, x, y, n, idx;
    sq = mag * mag;
    lam = 64'(lambda_q);
    x = lam * (sq >> 32) + ((lam * (sq & 64'hFFFFFFFF)) >> 32);
    if (x >= (64'd32 << 24)) return 64'd0;
    y = 64'((128'(x) * LOG2E_Q30) >> 30);
    n = y >> 24;
    idx = ((y & 64'hFFFFFF) * EXP_DEPTH) >> 24;
    if (n >= 32 || idx >= EXP_DEPTH) return 64'd0;
    return 64'(exp_rom[idx]) >> n;
  endfunction

  // signed quotient in Q8.24, truncated toward zero
  function automatic logic signed [63:0] offset_quotient(logic signed [63:0] num,
                                                          logic [63:0] s);
    logic neg;
    logic [63:0] mag, qi, r, f1, f2, q;
    neg = num < 0;
    mag = neg ? -num : num;
    qi = mag / s;
    r = mag % s;
    f1 = (r << 12) / s;
    r = (r << 12) % s;
    f2 = (r << 12) / s;
    q = (qi << 24) | (f1 << 12) | f2;
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic void predict_bin(in_item_t it);
    logic [63:0] prob, mag, w, wp, s, value, tot, qm, dm, gm;
    logic signed [63:0] wd, wpd, q1, q2, t, d;
    logic neg;
    logic signed [47:0] grad;
    out_item_t r;
    prob = 64'(it.bin_probability);
    if (prob > 65536) prob = 65536;
    if (bins_in_pair < NUM_BINS_MAX) begin
      neg = it.bin_center < it.pair_distance;
      mag = neg ? 64'(it.pair_distance - it.bin_center)
                : 64'(it.bin_center - it.pair_distance);
      w = gauss_weight(mag);
      wp = (w * prob) >> 16;
      wd = $signed((w * mag) >> 24);
      wpd = $signed((wp * mag) >> 24);
      acc_w += w;
      acc_wp += wp;
      acc_wd += neg ? -wd : wd;
      acc_wpd += neg ? -wpd : wpd;
      bins_in_pair++;
    end
    if (!it.last_bin) return;
    value = 0;
    grad = 0;
    s = 64'(epsilon_q) + acc_w;
    if (s != 0) begin
      value = (acc_wp << 16) / s;
      if (value > 65536) value = 65536;
      q1 = offset_quotient(acc_wpd, s);
      q2 = offset_quotient(acc_wd, s);
      qm = q2 < 0 ? -q2 : q2;
      t = $signed((value * qm) >> 16);
      if (q2 < 0) t = -t;
      d = q1 - t;
      neg = d < 0;
      dm = neg ? -d : d;
      gm = 64'((128'(lambda_q) * dm) >> 15);
      if (neg) grad = (gm > 64'h800000000000) ? 48'sh800000000000 : -48'(gm);
      else grad = (gm > 64'h7FFFFFFFFFFF) ? 48'sh7FFFFFFFFFFF : 48'(gm);
    end
    tot = 64'(running_total) + value;
    if (tot > 64'hFFFFFFFF) tot = 64'hFFFFFFFF;
    running_total = tot[31:0];
    r.pair_value = value[16:0];
    r.pair_gradient = grad;
    r.total_value = tot[31:0];
    r.total_final = it.last_pair;
    pair_results_q.push_back(r);
    acc_w = 0;
    acc_wp = 0;
    acc_wd = 0;
    acc_wpd = 0;
    bins_in_pair = 0;
    if (it.last_pair) running_total = 0;
  endfunction

  function automatic bit idle_draw();
    return ($urandom_range(99) < 68);
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pair_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        out_item_t e;
        e = pair_results_q.pop_front();
        if (out_data.total_final) finals_seen++;
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", e, out_data);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (phase == PH_SNK_STALL) out_stall <= idle_draw();
    else if (phase == PH_BOTH) out_stall <= ($urandom_range(99) < 6);
    else out_stall <= 1'b0;
  end

  // valid stays up after an accepted item until the sender idles or waits
  task automatic send_bin(in_item_t it);
    int gap;
    gap = 0;
    if (phase == PH_SRC_IDLE) begin
      while (idle_draw()) gap++;
    end else if (phase == PH_BOTH) begin
      while ($urandom_range(99) < 6) gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_bin(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pair_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LAMBDA) lambda_q = val[23:0];
    else epsilon_q = val;
  endtask

  function automatic in_item_t rand_bin(bit lb, bit lp);
    in_item_t it;
    logic [31:0] c;
    it.pair_distance = $urandom();
    c = it.pair_distance + ($urandom_range(1) ? 32'($signed($urandom()) >>> 7)
                                              : $urandom());
    it.bin_center = c;
    case ($urandom_range(3))
      0: it.bin_probability = $urandom_range(131071);
      1: it.bin_probability = PROB_ONE;
      default: it.bin_probability = $urandom_range(65536);
    endcase
    it.last_bin = lb;
    it.last_pair = lp;
    return it;
  endfunction

  // one pair of random length, with occasional overlong pairs and noise
  task automatic send_pair(bit final_pair);
    int n;
    n = ($urandom_range(19) == 0) ? $urandom_range(65, 70) : $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      send_bin(rand_bin(i == n - 1, (i == n - 1) ? final_pair : $urandom_range(1)));
  endtask

  // directed table: pair_distance, bin_center, probability, last_bin, last_pair
  in_item_t directed_tbl[] = '{
    '{32'h0100_0000, 32'h0100_0000, 17'd65536, 1'b1, 1'b0},
    '{32'h0000_0000, 32'hFFFF_FFFF, 17'd65536, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 32'h0000_0000, 17'd1, 1'b1, 1'b1},
    '{32'h0200_0000, 32'h0280_0000, 17'h1FFFF, 1'b0, 1'b1},
    '{32'h0200_0000, 32'h01C0_0000, 17'd0, 1'b0, 1'b0},
    '{32'h0200_0000, 32'h0200_0000, 17'd32768, 1'b1, 1'b0},
    '{32'h0300_0000, 32'h0310_0000, 17'd40000, 1'b0, 1'b0},
    '{32'h0300_0000, 32'h02F0_0000, 17'd20000, 1'b1, 1'b1},
    '{32'h0000_0000, 32'h0000_0000, 17'd0, 1'b1, 1'b1}
  };
  // typed-in checks: exact center gives full weight, far bin gives zero weight
  logic [16:0] directed_value[] = '{17'd65536, 17'd0, 17'd0};

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_LAMBDA;
    cfg_data = '0;
    phase = PH_NONE;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    finals_seen = 0;
    build_exp_rom();
    lambda_q = 24'd256;
    epsilon_q = 0;
    acc_w = 0;
    acc_wp = 0;
    acc_wd = 0;
    acc_wpd = 0;
    running_total = 0;
    bins_in_pair = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at reset settings
    for (int i = 0; i < directed_tbl.size(); i++) begin
      send_bin(directed_tbl[i]);
      if (i < directed_value.size() && pair_results_q.size() != 0 &&
          pair_results_q[$].pair_value !== directed_value[i]) begin
        mismatches++;
        $display("directed row %0d: expected value %0d", i, directed_value[i]);
      end
    end
    // too many bins in one pair
    for (int i = 0; i < 66; i++) send_bin(rand_bin(i == 65, 1'b0));
    wait_idle();

    // zero denominator with epsilon at zero and extreme lambda
    write_reg(CFG_LAMBDA, 32'hFFFFFF);
    send_bin('{32'h0000_0000, 32'h8000_0000, 17'd65536, 1'b1, 1'b1});
    wait_idle();
    write_reg(CFG_EPSILON, 32'hFFFFFFFF);
    send_bin('{32'h0100_0000, 32'h0100_0000, 17'd65536, 1'b1, 1'b0});
    wait_idle();

    // random part across settings and idling phases
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: write_reg(CFG_LAMBDA, 32'(($urandom_range(1)) ? $urandom_range(16, 1024)
                                                          : $urandom_range(0, 24'hFFFFFF)));
        1: write_reg(CFG_EPSILON, $urandom_range(1) ? 32'd0 : $urandom_range(0, 65535));
        2: write_reg(CFG_LAMBDA, (ph == 2) ? 32'd0 : 32'd256);
        default: write_reg(CFG_EPSILON, (ph == 3) ? 32'hFFFFFFFF : $urandom());
      endcase
      phase = idle_phase_e'(ph % 4);
      while (items_sent < (ph + 1) * RANDOM_ITEMS / 8) begin
        if ($urandom_range(9) == 0) send_bin(rand_bin(1'b0, 1'b1));
        else send_pair($urandom_range(7) == 0);
      end
      // sender holds off until all results are back
      if (ph == 4) begin
        in_valid <= 1'b0;
        while (pair_results_q.size() != 0) @(negedge clk);
      end
      send_pair(1'b1);
      wait_idle();
    end

    $display("sent %0d bins, checked %0d pair results, %0d final totals",
             items_sent, results_seen, finals_seen);
    $display("covered extreme lambda and epsilon, overlong pairs and four idling phases");
    if (mismatches == 0 && pair_results_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // overall limit
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/gbpi_pkg.sv
rtl/core/gbpi_div.sv
rtl/core/gbpi_front.sv
rtl/core/gbpi_queue.sv
rtl/core/gbpi_back.sv
rtl/core/gaussian_bin_probability_interpolate_core.sv
rtl/core/gbpi_checker.sv
bench/gaussian_bin_probability_interpolate_core_tb.sv
